// ----- rtl/seeded_superfasthash_stream_assert.svh -----
// Assertion macros for the checker file of the hash stream block.
// Holds only macro definitions; no dependencies.
`ifndef SEEDED_SUPERFASTHASH_STREAM_ASSERT_SVH
`define SEEDED_SUPERFASTHASH_STREAM_ASSERT_SVH

// Concurrent assertion that is checked at every edge, reset included.
`define SFH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// Concurrent assertion that is switched off while the reset is applied.
`define SFH_ASSERT_RUN(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`endif

// ----- rtl/sfh_pkg.sv -----
// Package for the seeded SuperFastHash stream: field widths, item type and
// the mixing, tail and avalanche functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sfh_pkg;

    localparam int WORD_W  = 32;
    localparam int CNT_W   = 3;
    localparam int HASH_W  = 32;
    localparam int SDATA_W = 72;
    localparam int MDATA_W = 32;

    localparam logic [CNT_W-1:0] CNT_NONE = 3'd0;
    localparam logic [CNT_W-1:0] CNT_ONE  = 3'd1;
    localparam logic [CNT_W-1:0] CNT_TWO  = 3'd2;
    localparam logic [CNT_W-1:0] CNT_THREE = 3'd3;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [CNT_W-1:0]  byte_count;
        logic              first;
        logic              last;
        logic [HASH_W-1:0] seed;
    } sfh_item_t;

    function automatic logic [HASH_W-1:0] full_round(input logic [HASH_W-1:0] h_in,
                                                     input logic [WORD_W-1:0] w);
        logic [HASH_W-1:0] h;
        logic [HASH_W-1:0] t;
        h = h_in + {16'd0, w[15:0]};
        t = ({16'd0, w[31:16]} << 11) ^ h;
        h = (h << 16) ^ t;
        h = h + (h >> 11);
        return h;
    endfunction

    function automatic logic [HASH_W-1:0] tail_mix(input logic [HASH_W-1:0] h_in,
                                                   input logic [WORD_W-1:0] w,
                                                   input logic [CNT_W-1:0]  n);
        logic [HASH_W-1:0] h;
        h = h_in;
        unique case (n)
            CNT_THREE: begin
                h = h + {16'd0, w[15:0]};
                h = h ^ (h << 16);
                h = h ^ ({24'd0, w[23:16]} << 18);
                h = h + (h >> 11);
            end
            CNT_TWO: begin
                h = h + {16'd0, w[15:0]};
                h = h ^ (h << 11);
                h = h + (h >> 17);
            end
            CNT_ONE: begin
                h = h + {24'd0, w[7:0]};
                h = h ^ (h << 10);
                h = h + (h >> 1);
            end
            default: begin
                h = h_in;
            end
        endcase
        return h;
    endfunction

    function automatic logic [HASH_W-1:0] avalanche(input logic [HASH_W-1:0] h_in);
        logic [HASH_W-1:0] h;
        h = h_in;
        h = h ^ (h << 3);
        h = h + (h >> 5);
        h = h ^ (h << 4);
        h = h + (h >> 17);
        h = h ^ (h << 25);
        h = h + (h >> 6);
        return h;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/seeded_superfasthash_stream.sv -----
// Top level of the seeded SuperFastHash stream: input register, running hash
// and result register. Depends on sfh_pkg and sfh_mix.
//
//   Channel   Direction   Signals                       Transaction
//   s_        in          s_tvalid s_tready s_tdata     one message word
//                         s_tuser s_tlast
//   m_        out         m_tvalid m_tready m_tdata     one hash per message
//
// One word is taken per cycle unless the input stalls; the result register takes the hash of a last word.
// The rate is set by the running-hash loop through the mixing logic.
// Reset clears the running hash to zero and empties both registers.
// A stalled result only holds the input register when it contains a last word.
`timescale 1ns / 1ps
`default_nettype none

module seeded_superfasthash_stream (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // word [31:0], byte_count [34:32], seed [66:35], zero fill [71:67]
    input  wire logic [sfh_pkg::SDATA_W-1:0]   s_tdata,
    // first [0]
    input  wire logic                          s_tuser,
    input  wire logic                          s_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // hash_value [31:0]
    output logic      [sfh_pkg::MDATA_W-1:0]   m_tdata
);
    import sfh_pkg::*;

    sfh_item_t         item_reg;
    logic              item_valid_reg;
    logic [HASH_W-1:0] run_hash_reg;
    logic [HASH_W-1:0] out_hash_reg;
    logic              out_valid_reg;
    logic [HASH_W-1:0] hash_next;
    logic              advance;
    logic              s_take;
    logic              m_take;

    assign m_take   = out_valid_reg && m_tready;
    assign advance  = item_valid_reg && (!item_reg.last || !out_valid_reg || m_tready);
    assign s_tready = !item_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    sfh_mix u_mix (
        .item         (item_reg),
        .running_hash (run_hash_reg),
        .hash_next    (hash_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            run_hash_reg   <= '0;
        end else begin
            if (s_take) begin
                item_valid_reg <= 1'b1;
            end else if (advance) begin
                item_valid_reg <= 1'b0;
            end
            if (advance) begin
                run_hash_reg <= hash_next;
            end
            if (advance && item_reg.last) begin
                out_valid_reg <= 1'b1;
            end else if (m_take) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            item_reg.word       <= s_tdata[31:0];
            item_reg.byte_count <= s_tdata[34:32];
            item_reg.seed       <= s_tdata[66:35];
            item_reg.first      <= s_tuser;
            item_reg.last       <= s_tlast;
        end
        if (advance && item_reg.last) begin
            out_hash_reg <= hash_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_hash_reg;

endmodule

`default_nettype wire

// ----- rtl/sfh_mix.sv -----
// Combinational next-hash logic for one word of the hash stream.
// Depends on sfh_pkg for the item type and the mixing functions.
`timescale 1ns / 1ps
`default_nettype none

module sfh_mix (
    input  wire sfh_pkg::sfh_item_t        item,
    input  wire logic [sfh_pkg::HASH_W-1:0] running_hash,
    output logic      [sfh_pkg::HASH_W-1:0] hash_next
);
    import sfh_pkg::*;

    logic [HASH_W-1:0] h_start;
    logic              full_word;

    assign h_start   = item.first ? item.seed : running_hash;
    assign full_word = (item.byte_count >= 3'd4);

    always_comb begin
        priority if (!item.last) begin
            hash_next = full_round(h_start, item.word);
        end else if (item.first && (item.byte_count == CNT_NONE)) begin
            hash_next = '0;
        end else if (full_word) begin
            hash_next = avalanche(full_round(h_start, item.word));
        end else begin
            hash_next = avalanche(tail_mix(h_start, item.word, item.byte_count));
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sfh_checker.sv -----
// Port-level checker for the seeded SuperFastHash stream, bound to the top.
// Depends on sfh_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none

`include "seeded_superfasthash_stream_assert.svh"

module sfh_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_tready,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [sfh_pkg::MDATA_W-1:0] m_tdata
);
    import sfh_pkg::*;

    // A result waiting for the sink keeps its value until the transaction.
    `SFH_ASSERT_RUN(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled hash changed or vanished")

    // The output is empty right after reset.
    `SFH_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // The input only stalls when a finished hash is blocked at the output.
    `SFH_ASSERT_RUN(a_stall_cause, aclk, aresetn, !s_tready |-> (m_tvalid && !m_tready), "input stalled without output backpressure")

endmodule

bind seeded_superfasthash_stream sfh_checker u_sfh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- tb/tb_seeded_superfasthash_stream.sv -----
// Self-checking testbench for seeded_superfasthash_stream: random and directed messages
// go through the stream ports, and each hash is compared with an in-bench prediction.
// Depends on sfh_pkg for widths and byte-count codes, and on the block itself.
`timescale 1ns / 1ps

module tb_seeded_superfasthash_stream;

    import sfh_pkg::*;

    localparam int TOTAL_ITEMS = 1350;
    localparam int FILL_W = SDATA_W - HASH_W - CNT_W - WORD_W;
    localparam logic [CNT_W-1:0] CNT_FULL = 3'd4;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic [CNT_W-1:0]  byte_count;
        logic              first;
        logic              last;
        logic [HASH_W-1:0] seed;
        bit                drain;
    } msg_word_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [SDATA_W-1:0]  s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [MDATA_W-1:0]  m_tdata;

    msg_word_t         pending_q[$];
    logic [HASH_W-1:0] hash_q[$];
    logic [HASH_W-1:0] chain_hash = '0;

    int words_sent = 0;
    int words_taken = 0;
    int hashes_got = 0;
    int mismatches = 0;
    int send_gap = 0;
    bit send_idle = 1'b1;
    int recv_stall = 0;
    int recv_seen = 0;
    bit recv_idle = 1'b1;
    int lasts_by_count[8];

    seeded_superfasthash_stream dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
    end

    function automatic logic [HASH_W-1:0] mix_word(input logic [HASH_W-1:0] h,
                                                   input logic [WORD_W-1:0] w);
        logic [HASH_W-1:0] acc;
        logic [HASH_W-1:0] tmp;
        acc = h + HASH_W'(w[15:0]);
        tmp = (HASH_W'(w[31:16]) << 11) ^ acc;
        acc = (acc << 16) ^ tmp;
        return acc + (acc >> 11);
    endfunction

    function automatic logic [HASH_W-1:0] mix_tail(input logic [HASH_W-1:0] h,
                                                   input logic [WORD_W-1:0] w,
                                                   input logic [CNT_W-1:0]  n);
        logic [HASH_W-1:0] acc;
        acc = h;
        if (n == CNT_THREE) begin
            acc = acc + HASH_W'(w[15:0]);
            acc = acc ^ (acc << 16);
            acc = acc ^ (HASH_W'(w[23:16]) << 18);
            acc = acc + (acc >> 11);
        end else if (n == CNT_TWO) begin
            acc = acc + HASH_W'(w[15:0]);
            acc = acc ^ (acc << 11);
            acc = acc + (acc >> 17);
        end else if (n == CNT_ONE) begin
            acc = acc + HASH_W'(w[7:0]);
            acc = acc ^ (acc << 10);
            acc = acc + (acc >> 1);
        end
        return acc;
    endfunction

    function automatic logic [HASH_W-1:0] finish_hash(input logic [HASH_W-1:0] h);
        logic [HASH_W-1:0] acc;
        acc = h;
        acc = acc ^ (acc << 3);
        acc = acc + (acc >> 5);
        acc = acc ^ (acc << 4);
        acc = acc + (acc >> 17);
        acc = acc ^ (acc << 25);
        acc = acc + (acc >> 6);
        return acc;
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_item(input logic [WORD_W-1:0] word, input logic [CNT_W-1:0] cnt,
                              input bit first, input bit last,
                              input logic [HASH_W-1:0] seed, input bit drain);
        msg_word_t item;
        item.word = word;
        item.byte_count = cnt;
        item.first = first;
        item.last = last;
        item.seed = seed;
        item.drain = drain;
        pending_q.push_back(item);
    endtask

    task automatic note_mismatch(input string what, input logic [HASH_W-1:0] expected,
                                 input logic [HASH_W-1:0] actual);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: expected %08h, got %08h", $realtime, what, expected, actual);
        end
    endtask

    always @(negedge aclk) begin : drive_input
        msg_word_t cur;
        bit present;
        present = s_tvalid;
        if (aresetn && words_sent == words_taken) begin
            present = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_q.size() > 0 && !(pending_q[0].drain && hash_q.size() > 0)) begin
                cur = pending_q.pop_front();
                s_tdata <= {{FILL_W{1'b0}}, cur.seed, cur.byte_count, cur.word};
                s_tuser <= cur.first;
                s_tlast <= cur.last;
                present = 1'b1;
                words_sent++;
                if (words_sent % 64 == 0) begin
                    send_idle = 1'($urandom_range(0, 1));
                end
                send_gap = send_idle ? $urandom_range(0, 9) : 0;
            end
        end
        s_tvalid <= present;
    end

    always @(negedge aclk) begin : drive_ready
        if (recv_seen != hashes_got) begin
            recv_seen = hashes_got;
            if (hashes_got % 40 == 0) begin
                recv_idle = 1'($urandom_range(0, 1));
            end
            recv_stall = recv_idle ? $urandom_range(0, 9) : 0;
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : watch
        logic [WORD_W-1:0] w;
        logic [CNT_W-1:0]  n;
        logic [HASH_W-1:0] h;
        if (aresetn && s_tvalid && s_tready) begin
            words_taken++;
            w = s_tdata[WORD_W-1:0];
            n = s_tdata[WORD_W +: CNT_W];
            h = s_tuser ? s_tdata[WORD_W+CNT_W +: HASH_W] : chain_hash;
            if (!s_tlast) begin
                chain_hash = mix_word(h, w);
            end else begin
                lasts_by_count[n]++;
                if (s_tuser && n == CNT_NONE) begin
                    h = '0;
                end else begin
                    h = (n >= CNT_FULL) ? mix_word(h, w) : mix_tail(h, w, n);
                    h = finish_hash(h);
                end
                chain_hash = h;
                hash_q.push_back(h);
            end
        end
        if (aresetn && m_tvalid && m_tready) begin
            hashes_got++;
            if (hash_q.size() == 0) begin
                note_mismatch("hash with no message pending", '0, m_tdata);
            end else begin
                h = hash_q.pop_front();
                if (m_tdata !== h) begin
                    note_mismatch("hash_value", h, m_tdata);
                end
            end
        end
    end

    initial begin : stimulus
        int len;
        logic [CNT_W-1:0] cnt;
        logic [HASH_W-1:0] seed;

        // Words before any first item continue from the reset value.
        queue_item(32'hFFFF_FFFF, CNT_NONE, 1'b0, 1'b0, 32'h1234_5678, 1'b0);
        queue_item(32'h0000_0000, CNT_FULL, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0);
        queue_item(32'hDEAD_BEEF, CNT_NONE, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0);
        queue_item(32'h8080_8080, CNT_ONE, 1'b0, 1'b1, 32'h0, 1'b0);
        queue_item(32'hFFFF_FFFF, CNT_ONE, 1'b1, 1'b1, 32'h0, 1'b1);
        queue_item(32'hFFFF_FFFF, CNT_TWO, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0);
        queue_item(32'hFFFF_FFFF, CNT_THREE, 1'b1, 1'b1, 32'h0, 1'b0);
        queue_item(32'h0000_0000, CNT_THREE, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0);
        queue_item(32'hFFFF_FFFF, CNT_FULL, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0);
        queue_item(32'hA5A5_5A5A, 3'd5, 1'b1, 1'b1, 32'h0F0F_F0F0, 1'b0);
        queue_item(32'h0123_4567, 3'd7, 1'b1, 1'b1, 32'h8000_0001, 1'b0);
        queue_item(32'h89AB_CDEF, 3'd6, 1'b1, 1'b1, 32'h7FFF_FFFE, 1'b0);
        // Byte count is ignored on words that do not end the message.
        queue_item(32'hFFFF_FFFF, 3'd7, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0);
        queue_item(32'h0000_0000, CNT_NONE, 1'b0, 1'b0, 32'h0, 1'b0);
        queue_item(32'h5555_AAAA, CNT_NONE, 1'b0, 1'b1, 32'h0, 1'b0);
        queue_item(32'h1111_2222, CNT_FULL, 1'b1, 1'b0, 32'h0, 1'b0);
        queue_item(32'h3333_4444, CNT_TWO, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0);
        queue_item(32'hCAFE_F00D, CNT_FULL, 1'b0, 1'b0, 32'h0, 1'b0);
        queue_item(32'hFFFF_FF00, CNT_ONE, 1'b0, 1'b1, 32'h0, 1'b0);
        queue_item(32'h7F7F_7F7F, CNT_FULL, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0);
        queue_item(32'h0000_FFFF, CNT_FULL, 1'b1, 1'b0, 32'h0000_0000, 1'b0);
        queue_item(32'hFF00_FF00, CNT_THREE, 1'b0, 1'b1, 32'h0, 1'b0);

        while (pending_q.size() < TOTAL_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                queue_item($urandom, CNT_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), $urandom, 1'b0);
            end else begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 16) : $urandom_range(0, 3);
                seed = rand_word();
                for (int i = 0; i < len; i++) begin
                    cnt = ($urandom_range(0, 4) == 0) ? CNT_W'($urandom_range(0, 7)) : CNT_FULL;
                    queue_item(rand_word(), cnt, i == 0, 1'b0, (i == 0) ? seed : $urandom,
                               (i == 0) && ($urandom_range(0, 39) == 0));
                end
                cnt = ($urandom_range(0, 9) == 0) ? CNT_W'($urandom_range(5, 7))
                                                  : CNT_W'($urandom_range(0, 4));
                queue_item(rand_word(), cnt, len == 0, 1'b1, (len == 0) ? seed : $urandom,
                           (len == 0) && ($urandom_range(0, 39) == 0));
            end
        end

        wait (pending_q.size() == 0 && words_sent == words_taken);
        wait (hash_q.size() == 0);
        repeat (10) @(posedge aclk);

        if (hash_q.size() != 0) begin
            mismatches++;
            $display("%0d hashes never arrived", hash_q.size());
        end
        $display("Run covered %0d words and %0d hashes, %0d mismatches.",
                 words_taken, hashes_got, mismatches);
        $display("Last words by byte count 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 lasts_by_count[0], lasts_by_count[1], lasts_by_count[2], lasts_by_count[3],
                 lasts_by_count[4], lasts_by_count[5], lasts_by_count[6], lasts_by_count[7]);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d words pending and %0d hashes outstanding.",
                 pending_q.size(), hash_q.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
